### design/smcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_pkg
// shared types and constants of the sensor min/max calibrate and scale block
// ----------------------------------------------------------------------------
package smcs_pkg;

    // channel and sample geometry
    localparam int NUM_CHANNELS = 10;
    localparam int SAMPLE_BITS  = 12;
    localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // field widths of the transactions
    localparam int CMD_W   = 2;
    localparam int CH_W    = 4;
    localparam int RAW_W   = 12;
    localparam int SCALE_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;

    // divider geometry: dividend is (raw - low) * full_scale
    localparam int PROD_W = SAMPLE_BITS + SCALE_W;
    localparam int QUOT_W = SCALE_W;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    localparam logic [TICK_W-1:0]  DURATION_RESET   = TICK_W'(10000);
    localparam logic [SCALE_W-1:0] FULL_SCALE_RESET = SCALE_W'(1000);

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_START  = 2'd1,
        CMD_END    = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DURATION   = 1'b0,
        REG_FULL_SCALE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] lo;
    } bound_entry_t;

    typedef struct packed {
        logic         en;
        logic [IDX_W-1:0] addr;
        bound_entry_t data;
    } mem_wr_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

    localparam bound_entry_t BOUND_RESET = '{hi: '0, lo: SAMPLE_MAX};

endpackage
`default_nettype wire

### design/smcs_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smcs interfaces
// valid/ready channels for sample commands and scaled results
// ----------------------------------------------------------------------------
interface smcs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [3:0]  channel;
    logic [11:0] raw_sample;

    modport source (output valid, output cmd, output channel, output raw_sample,
                    input ready);
    modport sink   (input valid, input cmd, input channel, input raw_sample,
                    output ready);
endinterface

interface smcs_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  out_channel;
    logic [15:0] scaled_value;
    logic        calibrating;
    logic        span_valid;

    modport source (output valid, output out_channel, output scaled_value,
                    output calibrating, output span_valid, input ready);
    modport sink   (input valid, input out_channel, input scaled_value,
                    input calibrating, input span_valid, output ready);
endinterface
`default_nettype wire

### design/sensor_minmax_calibrate_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_minmax_calibrate_scale
// multi-channel min/max calibrating normalizer with serial rescale divider
// ----------------------------------------------------------------------------
// steps: a sample passes through bound read, bound update, multiply,
//   divider load, the serial divide and result load; an empty span skips
//   the divider, and the serial divide is the longest step
// flow: one sample at a time; no new transaction is taken until the last
//   sample's result is loaded, and later still while a waiting result holds
//   the sequencer; start, end, tick and out-of-range samples give no result
//   and leave the sequencer idle
// reset: bounds read as low 4095 / high 0, calibration off, tick count zero,
//   duration 10000, full scale 1000; a start transaction clears the bound
//   store at once through its valid bits, so no clearing pass is needed
// ----------------------------------------------------------------------------
module sensor_minmax_calibrate_scale (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [smcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [smcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    smcs_in_if.sink                            in_ch,
    smcs_out_if.source                         out_ch
);
    import smcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    // control state
    state_t              state_reg,      state_next;
    logic                cal_active_reg, cal_active_next;
    logic [TICK_W-1:0]   ticks_reg,      ticks_next;
    logic [TICK_W-1:0]   dur_reg,        dur_next;
    logic [SCALE_W-1:0]  fs_reg,         fs_next;
    logic                out_valid_reg,  out_valid_next;

    // item payload carried through the steps
    logic [CH_W-1:0]        item_ch_reg;
    logic [SAMPLE_BITS-1:0] item_raw_reg;
    logic                   item_cal_reg;
    logic [SAMPLE_BITS-1:0] diff_reg;
    logic [SAMPLE_BITS-1:0] span_reg;
    logic                   span_ok_reg;
    logic [PROD_W-1:0]      prod_reg;

    // result register
    logic [CH_W-1:0]    out_ch_reg;
    logic [SCALE_W-1:0] out_scaled_reg;
    logic               out_cal_reg;
    logic               out_span_reg;

    // handshake decode
    logic in_fire;
    logic out_free;
    logic sample_ok;
    logic load_out;

    // bound store
    mem_wr_t      bound_wr;
    logic         rd_en;
    logic         bound_clear;
    bound_entry_t rd_bound;

    // bound update and clamp on the word read back
    logic [SAMPLE_BITS-1:0] lo_new;
    logic [SAMPLE_BITS-1:0] hi_new;
    logic [SAMPLE_BITS-1:0] clamped;
    logic                   span_ok;

    logic [TICK_W-1:0] ticks_inc;

    div_ctrl_t          div_req;
    div_ctrl_t          div_rsp;
    logic [QUOT_W-1:0]  quotient;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign sample_ok   = (in_ch.cmd == CMD_SAMPLE) &&
                         (in_ch.channel < CH_W'(NUM_CHANNELS));
    assign load_out    = (state_reg == S_DONE) && out_free;

    assign rd_en       = in_fire && sample_ok;
    assign bound_clear = in_fire && (in_ch.cmd == CMD_START);

    // calibration widens the bounds to take in the sample; the sample is clamped to the bounds
    always_comb
    begin
        lo_new = rd_bound.lo;
        hi_new = rd_bound.hi;
        if (item_cal_reg && (item_raw_reg < rd_bound.lo))
        begin
            lo_new = item_raw_reg;
        end
        if (item_cal_reg && (item_raw_reg > rd_bound.hi))
        begin
            hi_new = item_raw_reg;
        end
        span_ok = (hi_new > lo_new);
        clamped = item_raw_reg;
        if (item_raw_reg < lo_new)
        begin
            clamped = lo_new;
        end
        else if (item_raw_reg > hi_new)
        begin
            clamped = hi_new;
        end
    end

    // write back every looked-up entry; unchanged outside calibration
    assign bound_wr = '{en:   (state_reg == S_LOOKUP),
                        addr: IDX_W'(item_ch_reg),
                        data: '{hi: hi_new, lo: lo_new}};

    assign ticks_inc = (ticks_reg == {TICK_W{1'b1}}) ? ticks_reg
                                                       : ticks_reg + TICK_W'(1);

    assign div_req = '{start: (state_reg == S_MUL) && span_ok_reg, done: 1'b0};

    // next-state logic for the sequencer and control registers
    always_comb
    begin
        state_next      = state_reg;
        cal_active_next = cal_active_reg;
        ticks_next      = ticks_reg;
        dur_next        = dur_reg;
        fs_next         = fs_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DURATION:   dur_next = cfg_wdata;
                REG_FULL_SCALE: fs_next  = cfg_wdata;
                default:        ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd_t'(in_ch.cmd))
                        CMD_SAMPLE:
                        begin
                            if (sample_ok)
                            begin
                                state_next = S_LOOKUP;
                            end
                        end
                        CMD_START:
                        begin
                            cal_active_next = 1'b1;
                            ticks_next      = '0;
                        end
                        CMD_END:
                        begin
                            cal_active_next = 1'b0;
                        end
                        CMD_TICK:
                        begin
                            if (cal_active_reg)
                            begin
                                ticks_next = ticks_inc;
                                if (ticks_inc >= dur_reg)
                                begin
                                    cal_active_next = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // an empty span skips the divider and reports full scale
                state_next = span_ok_reg ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cal_active_reg <= 1'b0;
            ticks_reg      <= '0;
            dur_reg        <= DURATION_RESET;
            fs_reg         <= FULL_SCALE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cal_active_reg <= cal_active_next;
            ticks_reg      <= ticks_next;
            dur_reg        <= dur_next;
            fs_reg         <= fs_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            item_ch_reg  <= in_ch.channel;
            item_raw_reg <= in_ch.raw_sample[SAMPLE_BITS-1:0];
            item_cal_reg <= cal_active_reg;
        end
        if (state_reg == S_LOOKUP)
        begin
            diff_reg    <= clamped - lo_new;
            span_reg    <= hi_new - lo_new;
            span_ok_reg <= span_ok;
        end
        if (state_reg == S_LOOKUP)
        begin
            prod_reg <= '0;
        end
        else if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(fs_reg);
        end
        if (load_out)
        begin
            out_ch_reg     <= item_ch_reg;
            out_scaled_reg <= span_ok_reg ? (fs_reg - quotient) : fs_reg;
            out_cal_reg    <= item_cal_reg;
            out_span_reg   <= span_ok_reg;
        end
    end

    // the product is registered in S_MUL; the divider latches it in the
    // following cycle through a delayed start
    div_ctrl_t div_start_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_reg <= '0;
        end
        else
        begin
            div_start_reg <= div_req;
        end
    end

    smcs_bound_mem u_bound_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (bound_clear),
        .wr      (bound_wr),
        .rd_en   (rd_en),
        .rd_addr (IDX_W'(in_ch.channel)),
        .rd_data (rd_bound)
    );

    smcs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (div_start_reg),
        .ctrl_out (div_rsp),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .quotient (quotient)
    );

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_channel  = out_ch_reg;
    assign out_ch.scaled_value = out_scaled_reg;
    assign out_ch.calibrating  = out_cal_reg;
    assign out_ch.span_valid   = out_span_reg;

    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide step");

    // bound store is never written and cleared in the same cycle
    a_no_wr_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bound_clear |-> !bound_wr.en)
        else $error("bound write collides with clear");

    // an empty span always reports full scale
    a_empty_span_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.span_valid) |-> (out_ch.scaled_value == fs_reg))
        else $error("empty span result is not full scale");

    // a result never exceeds full scale
    a_result_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.scaled_value <= fs_reg))
        else $error("scaled result above full scale");

endmodule
`default_nettype wire

### design/smcs_bound_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_bound_mem
// per-channel low/high bound store, registered read, valid bits
// ----------------------------------------------------------------------------
module smcs_bound_mem (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           clear,
    input  smcs_pkg::mem_wr_t             wr,
    input  wire                           rd_en,
    input  wire  [smcs_pkg::IDX_W-1:0]    rd_addr,
    output smcs_pkg::bound_entry_t        rd_data
);
    import smcs_pkg::*;

    bound_entry_t            mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    bound_entry_t            rd_data_reg;
    logic                    rd_hit_reg;

    // entry valid bits, cleared by reset and by a calibration start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : BOUND_RESET;

endmodule
`default_nettype wire

### design/smcs_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smcs_divider
// restoring serial divider, one quotient bit per cycle while busy
// ----------------------------------------------------------------------------
module smcs_divider (
    input  wire                              clk,
    input  wire                              rst_n,
    input  smcs_pkg::div_ctrl_t              ctrl_in,
    output smcs_pkg::div_ctrl_t              ctrl_out,
    input  wire  [smcs_pkg::PROD_W-1:0]      dividend,
    input  wire  [smcs_pkg::SAMPLE_BITS-1:0] divisor,
    output logic [smcs_pkg::QUOT_W-1:0]      quotient
);
    import smcs_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [QUOT_W-1:0]      work_reg;
    logic [SAMPLE_BITS-1:0] div_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [SAMPLE_BITS:0]   trial;
    logic                   ge;
    logic [SAMPLE_BITS:0]   diff;

    // quotient fits QUOT_W bits, so the top bits of the dividend are already
    // below the divisor and seed the partial remainder directly
    always_comb
    begin
        trial = {rem_reg, work_reg[QUOT_W-1]};
        ge    = (trial >= {1'b0, div_reg});
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_in.start)
        begin
            rem_reg  <= dividend[PROD_W-1 -: SAMPLE_BITS];
            work_reg <= dividend[QUOT_W-1:0];
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            work_reg <= {work_reg[QUOT_W-2:0], ge};
        end
    end

    assign ctrl_out = '{start: 1'b0, done: done_reg};
    assign quotient = work_reg;

endmodule
`default_nettype wire

### test/sensor_minmax_calibrate_scale_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_minmax_calibrate_scale_test
// self-checking bench for the min/max calibrating normalizer: a directed table
// covers reset values, extremes, clamping, ignored commands and tick-driven end
// of calibration, then random phases run under several register settings; every
// accepted sample is predicted and each result is compared field by field
// ----------------------------------------------------------------------------
module sensor_minmax_calibrate_scale_test;
    import smcs_pkg::*;

    // random transactions per register setting, and settle time after draining
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 6;
    localparam int SETTLE_CYCLES = 30;
    localparam int IDLE_PERCENT = 26;
    localparam int NUM_ROWS     = 26;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [SCALE_W-1:0] scaled;
        logic               calibrating;
        logic               span_valid;
    } scaled_result_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct {
        cmd_t               cmd;
        logic [CH_W-1:0]    channel;
        logic [RAW_W-1:0]   raw;
        bit                 typed;
        logic [SCALE_W-1:0] exp_scaled;
        bit                 exp_cal;
        bit                 exp_span;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    smcs_in_if  in_bus ();
    smcs_out_if out_bus ();

    sensor_minmax_calibrate_scale i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_bus),
        .out_ch    (out_bus)
    );

    // 8 time unit clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // predictor state: bounds per channel, calibration flag, tick counter
    // and the two registers as last written
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] bound_lo_q [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] bound_hi_q [NUM_CHANNELS];
    bit                     cal_on;
    logic [TICK_W-1:0]      tick_count;
    logic [TICK_W-1:0]      duration_reg;
    logic [SCALE_W-1:0]     full_scale_reg;

    scaled_result_t pending_results [$];
    int             error_count = 0;
    bit             steady = 1'b0;   // when set, neither side idles
    stim_row_t      directed_rows [NUM_ROWS];

    function automatic void clear_bounds();
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            bound_lo_q[i] = SAMPLE_MAX;
            bound_hi_q[i] = '0;
        end
    endfunction

    // advances the predictor by one transaction; returns 1 when a result is due
    function automatic bit calibrate_and_scale(input cmd_t c, input logic [CH_W-1:0] ch,
                                               input logic [RAW_W-1:0] raw,
                                               output scaled_result_t res);
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] clipped;
        logic [PROD_W-1:0]      prod;
        res = '0;
        case (c)
            CMD_START:
            begin
                clear_bounds();
                cal_on     = 1'b1;
                tick_count = '0;
                return 1'b0;
            end
            CMD_END:
            begin
                cal_on = 1'b0;
                return 1'b0;
            end
            CMD_TICK:
            begin
                if (cal_on)
                begin
                    if (tick_count != {TICK_W{1'b1}})
                        tick_count = tick_count + 1'b1;
                    if (tick_count >= duration_reg)
                        cal_on = 1'b0;
                end
                return 1'b0;
            end
            default:
            begin
            end
        endcase
        if (ch >= NUM_CHANNELS)
            return 1'b0;
        if (cal_on)
        begin
            if (raw < bound_lo_q[ch])
                bound_lo_q[ch] = raw;
            if (raw > bound_hi_q[ch])
                bound_hi_q[ch] = raw;
        end
        lo = bound_lo_q[ch];
        hi = bound_hi_q[ch];
        res.channel     = ch;
        res.calibrating = cal_on;
        if (hi > lo)
        begin
            clipped = (raw < lo) ? lo : ((raw > hi) ? hi : raw);
            prod    = PROD_W'(clipped - lo) * PROD_W'(full_scale_reg);
            res.scaled     = full_scale_reg - SCALE_W'(prod / PROD_W'(hi - lo));
            res.span_valid = 1'b1;
        end
        else
        begin
            res.scaled     = full_scale_reg;
            res.span_valid = 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // register write; the block is idle whenever this is called
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DURATION)
            duration_reg = value;
        else
            full_scale_reg = value;
        @(posedge clk);
    endtask

    // presents one transaction, waits for acceptance, then records the expectation
    task automatic drive_transaction(input cmd_t c, input logic [CH_W-1:0] ch,
                                     input logic [RAW_W-1:0] raw, input bit typed,
                                     input scaled_result_t typed_res);
        scaled_result_t res;
        bit             due;
        // random gap before the transaction, valid held low
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.cmd        <= c;
        in_bus.channel    <= ch;
        in_bus.raw_sample <= raw;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        // accepted at this edge
        due = calibrate_and_scale(c, ch, raw, res);
        if (due)
            pending_results.push_back(typed ? typed_res : res);
    endtask

    // mostly samples with extreme and narrow-window values, plus commands and
    // a few out-of-range channels
    task automatic drive_random_item();
        int               pick;
        int               val_pick;
        cmd_t             c;
        logic [CH_W-1:0]  ch;
        logic [RAW_W-1:0] raw;
        pick     = $urandom_range(0, 99);
        val_pick = $urandom_range(0, 99);
        if (pick < 6)
            c = CMD_START;
        else if (pick < 10)
            c = CMD_END;
        else if (pick < 22)
            c = CMD_TICK;
        else
            c = CMD_SAMPLE;
        if ($urandom_range(0, 99) < 6)
            ch = CH_W'($urandom_range(NUM_CHANNELS, 15));
        else
            ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
        if (val_pick < 8)
            raw = '0;
        else if (val_pick < 16)
            raw = {RAW_W{1'b1}};
        else if (val_pick < 30)
            raw = RAW_W'(2000 + $urandom_range(0, 3));   // tiny spans
        else
            raw = RAW_W'($urandom_range(0, 4095));
        drive_transaction(c, ch, raw, 1'b0, '0);
    endtask

    // lowers valid and waits until every expected result has come out
    task automatic drain_block();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and in-order compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        scaled_result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result on channel %0d value %0d",
                                          out_bus.out_channel, out_bus.scaled_value));
            else
            begin
                want = pending_results.pop_front();
                if (out_bus.out_channel !== want.channel)
                    report_mismatch($sformatf("out_channel got %0d want %0d",
                                              out_bus.out_channel, want.channel));
                if (out_bus.scaled_value !== want.scaled)
                    report_mismatch($sformatf("scaled_value got %0d want %0d (channel %0d)",
                                              out_bus.scaled_value, want.scaled,
                                              want.channel));
                if (out_bus.calibrating !== want.calibrating)
                    report_mismatch($sformatf("calibrating got %0b want %0b",
                                              out_bus.calibrating, want.calibrating));
                if (out_bus.span_valid !== want.span_valid)
                    report_mismatch($sformatf("span_valid got %0b want %0b",
                                              out_bus.span_valid, want.span_valid));
            end
        end
        out_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_W-1:0] dur;
        logic [CFG_DATA_W-1:0] fs;
        scaled_result_t        row_res;

        // every input known from time zero; out ready comes from the result side
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_DURATION;
        cfg_wdata         <= '0;
        in_bus.valid      <= 1'b0;
        in_bus.cmd        <= CMD_SAMPLE;
        in_bus.channel    <= '0;
        in_bus.raw_sample <= '0;

        // predictor starts from the reset state
        clear_bounds();
        cal_on         = 1'b0;
        tick_count     = '0;
        duration_reg   = DURATION_RESET;
        full_scale_reg = FULL_SCALE_RESET;

        // directed table; full scale stays at its reset value of 1000 throughout
        directed_rows = '{
            // after reset: bounds empty, not calibrating
            '{CMD_SAMPLE, 4'd0,  12'd100,  1'b1, 16'd1000, 1'b0, 1'b0},
            '{CMD_TICK,   4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},  // tick, idle
            '{CMD_END,    4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},  // end, idle
            '{CMD_START,  4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},
            // first sample makes a zero span
            '{CMD_SAMPLE, 4'd0,  12'd0,    1'b1, 16'd1000, 1'b1, 1'b0},
            '{CMD_SAMPLE, 4'd0,  12'd4095, 1'b1, 16'd0,    1'b1, 1'b1},
            '{CMD_SAMPLE, 4'd0,  12'd0,    1'b1, 16'd1000, 1'b1, 1'b1},
            '{CMD_SAMPLE, 4'd0,  12'd2048, 1'b0, 16'd0,    1'b0, 1'b0},
            '{CMD_SAMPLE, 4'd9,  12'd4095, 1'b1, 16'd1000, 1'b1, 1'b0},
            // channels past the last one are dropped
            '{CMD_SAMPLE, 4'd10, 12'd5,    1'b0, 16'd0,    1'b0, 1'b0},
            '{CMD_SAMPLE, 4'd15, 12'd4095, 1'b0, 16'd0,    1'b0, 1'b0},
            '{CMD_SAMPLE, 4'd9,  12'd1000, 1'b0, 16'd0,    1'b0, 1'b0},
            // restart while calibrating wipes the bounds
            '{CMD_START,  4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},
            '{CMD_SAMPLE, 4'd0,  12'd2048, 1'b1, 16'd1000, 1'b1, 1'b0},
            '{CMD_SAMPLE, 4'd0,  12'd3000, 1'b0, 16'd0,    1'b0, 1'b0},
            '{CMD_END,    4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},
            // clamping above and below the bounds
            '{CMD_SAMPLE, 4'd0,  12'd4095, 1'b1, 16'd0,    1'b0, 1'b1},
            '{CMD_SAMPLE, 4'd0,  12'd0,    1'b1, 16'd1000, 1'b0, 1'b1},
            '{CMD_SAMPLE, 4'd5,  12'd7,    1'b1, 16'd1000, 1'b0, 1'b0},
            '{CMD_END,    4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},  // end, idle
            // duration is 2 here: the second tick ends calibration
            '{CMD_START,  4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},
            '{CMD_TICK,   4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},
            '{CMD_SAMPLE, 4'd1,  12'd500,  1'b1, 16'd1000, 1'b1, 1'b0},
            '{CMD_SAMPLE, 4'd1,  12'd700,  1'b1, 16'd0,    1'b1, 1'b1},
            '{CMD_TICK,   4'd0,  12'd0,    1'b0, 16'd0,    1'b0, 1'b0},
            '{CMD_SAMPLE, 4'd1,  12'd600,  1'b0, 16'd0,    1'b0, 1'b0}
        };

        // single reset at the start
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short duration so the tick rows can end calibration; the tick while
        // idle is ignored, the two after the restart count
        write_reg(REG_DURATION, 16'd2);

        foreach (directed_rows[i])
        begin
            row_res.channel     = directed_rows[i].channel;
            row_res.scaled      = directed_rows[i].exp_scaled;
            row_res.calibrating = directed_rows[i].exp_cal;
            row_res.span_valid  = directed_rows[i].exp_span;
            drive_transaction(directed_rows[i].cmd, directed_rows[i].channel,
                              directed_rows[i].raw, directed_rows[i].typed, row_res);
        end
        drain_block();

        // random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    dur = 16'hFFFF;
                    fs  = 16'hFFFF;
                end
                1:
                begin
                    dur = 16'd1;
                    fs  = 16'd1;
                end
                2:
                begin
                    dur = 16'd12;
                    fs  = 16'd1000;
                end
                5:
                begin
                    dur = 16'hFFFF;
                    fs  = CFG_DATA_W'($urandom_range(1, 65535));
                end
                default:
                begin
                    dur = CFG_DATA_W'($urandom_range(2, 60));
                    fs  = CFG_DATA_W'($urandom_range(1, 65535));
                end
            endcase
            write_reg(REG_DURATION, dur);
            write_reg(REG_FULL_SCALE, fs);
            // phase 2 runs with no idling on either side
            steady = (p == 2);
            repeat (PHASE_ITEMS) drive_random_item();
            drain_block();
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog well past the slowest legal run
    initial
    begin
        #3200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
